>>> design/gmps_pkg.sv
// Package for the grid maximum path sum block: widths, defaults and shared types.
// Used by the interfaces, the row-store cell and the top level; depends on nothing.
package gmps_pkg;

   localparam int SUM_BITS           = 22;
   localparam int GRID_BITS          = 7;
   localparam int VALUE_FIELD_BITS   = 16;
   localparam int COLUMN_BITS        = 7;
   localparam int DEFAULT_MAX_N      = 64;
   localparam int DEFAULT_VALUE_BITS = 16;

   localparam logic [GRID_BITS-1:0] GRID_SIZE_RESET = 7'd64;

   typedef logic [SUM_BITS-1:0]         sum_type;
   typedef logic [GRID_BITS-1:0]        grid_type;
   typedef logic [VALUE_FIELD_BITS-1:0] value_type;
   typedef logic [COLUMN_BITS-1:0]      column_type;

   // Control handed to every cell of the row store.
   typedef struct packed {
      logic shift;   // an input beat is accepted this cycle
      logic load;    // this cell is the insertion point for the new sum
   } cell_ctl_type;

endpackage

>>> design/gmps_if.sv
// Valid/ready channel interfaces for the grid maximum path sum block.
// Depends on gmps_pkg for the payload types.
interface gmps_req_if;
   logic                 valid;
   logic                 ready;
   gmps_pkg::value_type  cell_value;

   modport source (output valid, output cell_value, input ready);
   modport sink   (input valid, input cell_value, output ready);
endinterface

interface gmps_rsp_if;
   logic                 valid;
   logic                 ready;
   gmps_pkg::sum_type    best_sum;
   gmps_pkg::column_type best_column;

   modport source (output valid, output best_sum, output best_column, input ready);
   modport sink   (input valid, input best_sum, input best_column, output ready);
endinterface

>>> design/gmps_cell.sv
// One cell of the row-store shift chain: holds one running path sum.
// Depends on gmps_pkg for the sum and control types.
module gmps_cell (
   input  logic                   clock,
   input  gmps_pkg::cell_ctl_type ctl,
   input  gmps_pkg::sum_type      new_sum,
   input  gmps_pkg::sum_type      prev_sum,
   output gmps_pkg::sum_type      held_sum
);

   gmps_pkg::sum_type sum_ff;
   gmps_pkg::sum_type sum_in;

   // The insertion cell takes the fresh sum; every other cell takes its left neighbour.
   always_comb begin
      sum_in = sum_ff;
      if (ctl.shift) begin
         sum_in = ctl.load ? new_sum : prev_sum;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
   end

   assign held_sum = sum_ff;

endmodule

>>> design/grid_max_path_sum_dp.sv
// Top level of the grid maximum path sum block: row-store cell chain, best tracker, output.
// Depends on gmps_pkg, the interfaces in gmps_if.sv and the cell module gmps_cell.
//
//   Channel   Direction  Handshake            Beat contents
//   req_chan  in         valid/ready          cell_value: next grid cell, row-major
//   rsp_chan  out        valid/ready          best_sum, best_column of a finished grid
//   csr_*     in         write enable only    grid_size (rows and columns)
//
// The block takes one cell per clock cycle, sustained, while the input is not stalled. The
// limiting path is the three-way maximum over the row above plus one add, which feeds the
// new sum straight back into the cell chain in the same cycle.
// A result passes from the tracker stage register into the output register and
// sits there until it is taken; a grid of N by N cells takes N*N input beats.
// Reset is synchronous and active high; the row store needs no clearing pass.
// The input side stalls only when a finished result waits in the tracker stage
// while the output register is still full and not being taken.
module grid_max_path_sum_dp #(
   parameter int MAX_N      = gmps_pkg::DEFAULT_MAX_N,
   parameter int VALUE_BITS = gmps_pkg::DEFAULT_VALUE_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   gmps_req_if.sink             req_chan,
   gmps_rsp_if.source           rsp_chan,
   input  logic                 csr_write_enable,
   input  gmps_pkg::grid_type   csr_write_data
);

   // Width of a column index and of a cell position in the chain.
   localparam int IDX_BITS = (MAX_N > 1) ? $clog2(MAX_N) : 1;

   // Only the low VALUE_BITS bits of a cell value take part in the sums.
   localparam gmps_pkg::value_type VAL_MASK =
      (VALUE_BITS >= gmps_pkg::VALUE_FIELD_BITS) ? '1
      : gmps_pkg::VALUE_FIELD_BITS'((64'd1 << VALUE_BITS) - 64'd1);

   // A grid size of zero behaves as one, and one above MAX_N as MAX_N.
   function automatic int effective_n(gmps_pkg::grid_type g);
      int n;
      n = int'(g);
      if (n < 1) begin
         n = 1;
      end
      if (n > MAX_N) begin
         n = MAX_N;
      end
      return n;
   endfunction

   // ------------------------------------------------------------------
   // Configuration and position counters
   // ------------------------------------------------------------------
   // The chain is made to look exactly N cells long by inserting new sums at
   // cell MAX_N-N; the sum written N beats ago then always sits in the last
   // cell, and the one written N-1 beats ago in the cell before it.
   logic [IDX_BITS-1:0] insert_pos_ff, insert_pos_in;
   logic [IDX_BITS-1:0] last_idx_ff,   last_idx_in;
   logic [IDX_BITS-1:0] row_ff,        row_in;
   logic [IDX_BITS-1:0] col_ff,        col_in;
   gmps_pkg::sum_type   left_ff,       left_in;

   // Tracker stage registers.
   logic                  s2_valid_ff,     s2_valid_in;
   gmps_pkg::sum_type     s2_sum_ff;
   logic [IDX_BITS-1:0]   s2_col_ff;
   logic                  s2_last_row_ff;
   logic                  s2_first_col_ff;
   logic                  s2_last_cell_ff;
   gmps_pkg::sum_type     best_ff,         best_in;
   gmps_pkg::column_type  best_col_ff,     best_col_in;

   // Output register.
   logic                  rsp_valid_ff,    rsp_valid_in;
   gmps_pkg::sum_type     rsp_sum_ff,      rsp_sum_in;
   gmps_pkg::column_type  rsp_col_ff,      rsp_col_in;

   logic                  accept;
   logic                  stall;
   logic                  advance;
   logic                  last_col;
   logic                  last_row;
   gmps_pkg::value_type   value_masked;
   gmps_pkg::sum_type     above_sum;
   gmps_pkg::sum_type     right_sum;
   gmps_pkg::sum_type     best_above;
   gmps_pkg::sum_type     new_sum;
   gmps_pkg::cell_ctl_type cell_ctl [MAX_N];
   gmps_pkg::sum_type     chain_q [MAX_N];
   logic                  take_new;
   gmps_pkg::sum_type     next_best;
   gmps_pkg::column_type  next_best_col;

   // A finished grid in the tracker stage cannot move while the output is full.
   assign stall    = s2_valid_ff && s2_last_cell_ff && rsp_valid_ff && !rsp_chan.ready;
   assign advance  = s2_valid_ff && !stall;
   assign req_chan.ready = !stall;
   assign accept   = req_chan.valid && !stall;

   assign last_col = (col_ff == last_idx_ff);
   assign last_row = (row_ff == last_idx_ff);

   // ------------------------------------------------------------------
   // Row-store chain
   // ------------------------------------------------------------------
   assign above_sum = chain_q[MAX_N-1];

   generate
      if (MAX_N > 1) begin : g_right
         assign right_sum = chain_q[MAX_N-2];
      end else begin : g_no_right
         assign right_sum = '0;
      end
   endgenerate

   for (genvar i = 0; i < MAX_N; i++) begin : g_cell
      assign cell_ctl[i].shift = accept;
      assign cell_ctl[i].load  = (insert_pos_ff == IDX_BITS'(i));

      if (i == 0) begin : g_head
         gmps_cell u_cell (
            .clock    (clock),
            .ctl      (cell_ctl[i]),
            .new_sum  (new_sum),
            .prev_sum (new_sum),
            .held_sum (chain_q[i])
         );
      end else begin : g_body
         gmps_cell u_cell (
            .clock    (clock),
            .ctl      (cell_ctl[i]),
            .new_sum  (new_sum),
            .prev_sum (chain_q[i-1]),
            .held_sum (chain_q[i])
         );
      end
   end

   // ------------------------------------------------------------------
   // Cell update: largest of the up to three sums above, plus this value
   // ------------------------------------------------------------------
   always_comb begin
      value_masked = req_chan.cell_value & VAL_MASK;
      best_above   = above_sum;
      if ((col_ff != '0) && (left_ff > best_above)) begin
         best_above = left_ff;
      end
      if (!last_col && (right_sum > best_above)) begin
         best_above = right_sum;
      end
      if (row_ff == '0) begin
         new_sum = gmps_pkg::SUM_BITS'(value_masked);
      end else begin
         new_sum = gmps_pkg::SUM_BITS'(value_masked) + best_above;
      end
   end

   // Counters, configuration and the saved left-hand sum of the row above.
   always_comb begin
      insert_pos_in = insert_pos_ff;
      last_idx_in   = last_idx_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      left_in       = left_ff;

      if (accept) begin
         // The entry about to be overwritten is the left neighbour of the next cell.
         left_in = (row_ff == '0) ? '0 : above_sum;
         if (last_col) begin
            col_in  = '0;
            left_in = '0;
            row_in  = last_row ? '0 : row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end

      if (csr_write_enable) begin
         insert_pos_in = IDX_BITS'(MAX_N - effective_n(csr_write_data));
         last_idx_in   = IDX_BITS'(effective_n(csr_write_data) - 1);
         row_in        = '0;
         col_in        = '0;
         left_in       = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         insert_pos_ff <= IDX_BITS'(MAX_N - effective_n(gmps_pkg::GRID_SIZE_RESET));
         last_idx_ff   <= IDX_BITS'(effective_n(gmps_pkg::GRID_SIZE_RESET) - 1);
         row_ff        <= '0;
         col_ff        <= '0;
         left_ff       <= '0;
      end else begin
         insert_pos_ff <= insert_pos_in;
         last_idx_ff   <= last_idx_in;
         row_ff        <= row_in;
         col_ff        <= col_in;
         left_ff       <= left_in;
      end
   end

   // ------------------------------------------------------------------
   // Tracker stage: running best of the last row, leftmost on ties
   // ------------------------------------------------------------------
   always_comb begin
      take_new      = s2_last_row_ff && (s2_first_col_ff || (s2_sum_ff > best_ff));
      next_best     = take_new ? s2_sum_ff : best_ff;
      next_best_col = take_new
                      ? gmps_pkg::COLUMN_BITS'(32'(s2_col_ff) + 32'd1)
                      : best_col_ff;

      s2_valid_in  = stall ? s2_valid_ff : accept;
      best_in      = best_ff;
      best_col_in  = best_col_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_sum_in   = rsp_sum_ff;
      rsp_col_in   = rsp_col_ff;

      if (advance) begin
         if (s2_last_cell_ff) begin
            // Grid complete: hand the result over and start afresh.
            rsp_valid_in = 1'b1;
            rsp_sum_in   = next_best;
            rsp_col_in   = next_best_col;
            best_in      = '0;
            best_col_in  = gmps_pkg::COLUMN_BITS'(1);
         end else begin
            best_in      = next_best;
            best_col_in  = next_best_col;
         end
      end

      if (csr_write_enable) begin
         best_in     = '0;
         best_col_in = gmps_pkg::COLUMN_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         best_ff      <= '0;
         best_col_ff  <= gmps_pkg::COLUMN_BITS'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff  <= s2_valid_in;
         best_ff      <= best_in;
         best_col_ff  <= best_col_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (accept) begin
         s2_sum_ff       <= new_sum;
         s2_col_ff       <= col_ff;
         s2_last_row_ff  <= last_row;
         s2_first_col_ff <= (col_ff == '0);
         s2_last_cell_ff <= last_row && last_col;
      end
      rsp_sum_ff <= rsp_sum_in;
      rsp_col_ff <= rsp_col_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.best_sum    = rsp_sum_ff;
   assign rsp_chan.best_column = rsp_col_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   // A result only appears after a finished grid has left the tracker stage.
   a_result_from_grid_end: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s2_valid_ff && s2_last_cell_ff))
      else $error("result raised without a completed grid");

   // The column counter never runs beyond the configured grid width.
   a_col_in_range: assert property (@(posedge clock) disable iff (reset)
      col_ff <= last_idx_ff)
      else $error("column counter beyond grid width");

   // Accepting the last cell of a grid wraps both counters to the origin.
   a_grid_wrap: assert property (@(posedge clock) disable iff (reset)
      (accept && last_row && last_col) |=> (row_ff == '0 && col_ff == '0))
      else $error("counters did not wrap after the last cell");

   // While the output is blocked, the finished grid waits in the tracker stage.
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      stall |=> (s2_valid_ff && s2_last_cell_ff))
      else $error("finished grid lost during an output stall");

endmodule
